[rtl/sine_stepper_position_driver_core_defines.svh]
// Assertion macros shared by the sine stepper position driver RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SINE_STEPPER_POSITION_DRIVER_CORE_DEFINES_SVH
`define SINE_STEPPER_POSITION_DRIVER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sspd_pkg.sv]
// Shared types, constants and the sine table generator for the sine stepper driver.
// No dependencies; all other files but the macro header import this package.
package sspd_pkg;

    localparam int ELAPSED_W  = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int POSOUT_W   = 32;
    localparam int DAC_W      = 8;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [15:0] BRAKE_LEVEL = 16'sd327;
    localparam logic [16:0] TIMER_MAX = 17'd131071;

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_BRAKE    = 2'd1,
        MODE_RELEASED = 2'd2,
        MODE_PULSE    = 2'd3
    } run_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RUN_MODE     = 3'd0,
        CFG_PHASE_RATE   = 3'd1,
        CFG_AMPLITUDE    = 3'd2,
        CFG_OFFSET_TGT   = 3'd3,
        CFG_OFFSET_SLEW  = 3'd4,
        CFG_DAC_GAIN     = 3'd5,
        CFG_DAC_PERIOD   = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_PHASE,
        ST_INDEX,
        ST_READ,
        ST_TARGET,
        ST_STEP,
        ST_DAC_ERR,
        ST_DAC_MUL,
        ST_DONE
    } seq_state_t;

    // Magnitude of sin(theta) in Q1.15 for theta in Q30 radians, first quadrant,
    // from a seven-term Taylor series evaluated in integers.
    function automatic logic [14:0] sine_mag(input logic [63:0] theta);
        logic [63:0] th2;
        logic [63:0] term;
        logic signed [64:0] sum;
        logic signed [64:0] rounded;
        logic [63:0] val;
        th2  = (theta * theta) >> 30;
        term = theta;
        sum  = $signed({1'b0, theta});
        term = ((term * th2) >> 30) / 6;
        sum  = sum - $signed({1'b0, term});
        term = ((term * th2) >> 30) / 20;
        sum  = sum + $signed({1'b0, term});
        term = ((term * th2) >> 30) / 42;
        sum  = sum - $signed({1'b0, term});
        term = ((term * th2) >> 30) / 72;
        sum  = sum + $signed({1'b0, term});
        term = ((term * th2) >> 30) / 110;
        sum  = sum - $signed({1'b0, term});
        term = ((term * th2) >> 30) / 156;
        sum  = sum + $signed({1'b0, term});
        if (sum < 0)
        begin
            sum = '0;
        end
        rounded = (sum + 65'sd16384) >>> 15;
        val = rounded[63:0];
        if (val > 64'd32767)
        begin
            val = 64'd32767;
        end
        return val[14:0];
    endfunction

endpackage

[rtl/sspd_if.sv]
// Handshake channel interfaces for the tick input and the result output.
// Depends on sspd_pkg for the field widths.
interface sspd_tick_if;
    import sspd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, output elapsed_us, input ready);
    modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface sspd_result_if;
    import sspd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       drive_disable;
    logic                       step_pulse;
    logic                       step_direction;
    logic signed [POSOUT_W-1:0] step_position;
    logic                       dac_update;
    logic [DAC_W-1:0]           dac_value;

    modport source (output valid, output drive_disable, output step_pulse,
                    output step_direction, output step_position, output dac_update,
                    output dac_value, input ready);
    modport sink   (input valid, input drive_disable, input step_pulse,
                    input step_direction, input step_position, input dac_update,
                    input dac_value, output ready);
endinterface

[rtl/sine_stepper_position_driver_core.sv]
// Sine stepper position driver. Each tick transaction carries the microseconds
// elapsed since the previous tick and produces exactly one result transaction:
// at most one microstep toward a sinusoidal target position, the driver disable
// flag, the updated position counter and, every dac_period microseconds, a sync
// DAC code of 128 plus the scaled position error, saturated to 0..255. A tick
// runs through the sequencer states from CALC to DONE, and the next tick is
// accepted once its result is in the output register, so ticks never overlap
// and a stalled output side holds the next tick off. The sequence is set by
// the two dependent reads of the registered sine ROM (the current phase
// decides whether the phase moves, the new phase gives the target) and by the
// registered multiply stages for the phase advance, the ROM index, the target
// and the two partial products of the DAC scaling. Configuration writes are
// taken in any cycle and must only be issued while the block is idle; a write of
// run_mode rearms single pulse mode.
`include "sine_stepper_position_driver_core_defines.svh"

module sine_stepper_position_driver_core #(
    parameter int SINE_DEPTH = 1024,
    parameter int POS_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sspd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sspd_pkg::CFG_DATA_W-1:0]  cfg_data,
    sspd_tick_if.sink                      tick,
    sspd_result_if.source                  result
);
    import sspd_pkg::*;

    localparam int IDX_W   = $clog2(SINE_DEPTH);
    localparam int DEPTH_W = $clog2(SINE_DEPTH) + 1;
    localparam int IPROD_W = 32 + DEPTH_W;
    // Width that holds both the position counter and the target's whole part.
    localparam int CMP_W   = ((POS_WIDTH > 22) ? POS_WIDTH : 22) + 1;
    // Width that holds both the position counter and the DAC clamp limit.
    localparam int PX_W    = (POS_WIDTH > 42) ? POS_WIDTH : 42;
    localparam int PE_W    = (POS_WIDTH > POSOUT_W) ? POS_WIDTH : POSOUT_W;

    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [PX_W-1:0] DAC_LIM_HI = PX_W'(64'sd1 <<< 40);
    localparam logic signed [PX_W-1:0] DAC_LIM_LO = -DAC_LIM_HI;

    // Configuration registers.
    run_mode_t          run_mode_reg;
    logic [31:0]        phase_rate_reg;
    logic [17:0]        amplitude_reg;
    logic signed [31:0] offset_target_reg;
    logic [15:0]        offset_slew_reg;
    logic [23:0]        dac_gain_reg;
    logic [15:0]        dac_period_reg;

    // Persistent motion state.
    logic [31:0]                 phase_acc_reg;
    logic [IDX_W-1:0]            phase_idx_reg;
    logic signed [POS_WIDTH-1:0] position_count_reg;
    logic signed [31:0]          offset_now_reg;
    logic [16:0]                 dac_timer_reg;
    logic                        pulse_done_reg;

    // Sequencer.
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       out_load;

    // Per-tick working registers.
    logic [ELAPSED_W-1:0] el_reg;
    logic [31:0]          dx_reg;
    logic [47:0]          adv_reg;
    logic                 go_reg;
    logic                 upd_reg;
    logic                 disable_reg;
    logic signed [35:0]   tprod_reg;
    logic                 step_reg;
    logic                 dir_reg;
    logic                 neg_reg;
    logic [56:0]          mag_reg;
    logic [48:0]          hi_reg;
    logic [55:0]          lo_reg;

    // Output register.
    logic                       out_valid_reg;
    logic                       out_disable_reg;
    logic                       out_pulse_reg;
    logic                       out_dir_reg;
    logic signed [POSOUT_W-1:0] out_position_reg;
    logic                       out_update_reg;
    logic [DAC_W-1:0]           out_code_reg;

    logic signed [15:0] rom_data;

    // The ROM always reads at the index of the stored phase, so its output is
    // the sine of the current phase from the cycle after the phase index settles.
    sspd_sine_rom #(
        .SINE_DEPTH (SINE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (phase_idx_reg),
        .data (rom_data)
    );

    // ---------------------------------------------------------------------
    // Sequencer: next state and handshake controls.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tick.ready = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick.ready = 1'b1;
                if (tick.valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:    state_next = ST_PHASE;
            ST_PHASE:   state_next = ST_INDEX;
            ST_INDEX:   state_next = ST_READ;
            ST_READ:    state_next = ST_TARGET;
            ST_TARGET:  state_next = ST_STEP;
            ST_STEP:    state_next = ST_DAC_ERR;
            ST_DAC_ERR: state_next = ST_DAC_MUL;
            ST_DAC_MUL: state_next = ST_DONE;
            ST_DONE:
            begin
                // Hold the finished result until the output register is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath combinational pieces, one group per sequencer step.
    // ---------------------------------------------------------------------

    // Tick arrival: elapsed-time products and the DAC timer.
    logic [17:0] timer_sum;
    logic [16:0] timer_sat;
    logic        upd_now;
    logic        go_now;
    logic        released;

    assign released  = (run_mode_reg == MODE_RELEASED);
    assign timer_sum = 18'(dac_timer_reg) + 18'(el_reg);
    assign timer_sat = (timer_sum > 18'(TIMER_MAX)) ? TIMER_MAX : timer_sum[16:0];
    assign upd_now   = !released && (timer_sat > 17'(dac_period_reg));

    // The phase moves unconditionally in sine mode and during the armed pulse;
    // brake mode (and a spent pulse) only keeps moving while the sine of the
    // current phase is clear of zero. rom_data holds that sine in ST_CALC.
    always_comb
    begin
        unique case (run_mode_reg)
            MODE_SINE:     go_now = 1'b1;
            MODE_RELEASED: go_now = 1'b0;
            MODE_PULSE:    go_now = !pulse_done_reg ||
                                    (rom_data > BRAKE_LEVEL) || (rom_data < -BRAKE_LEVEL);
            MODE_BRAKE:    go_now = (rom_data > BRAKE_LEVEL) || (rom_data < -BRAKE_LEVEL);
            default:       go_now = 1'b0;
        endcase
    end

    // Phase advance and offset slew.
    logic [48:0]        phase_sum;
    logic               phase_wrap;
    logic signed [33:0] off_x;
    logic signed [33:0] tgt_x;
    logic signed [33:0] dx_x;
    logic signed [33:0] off_sum;
    logic signed [31:0] off_next;

    assign phase_sum  = 49'(phase_acc_reg) + 49'(adv_reg);
    assign phase_wrap = |phase_sum[48:32];

    always_comb
    begin
        off_x = 34'(offset_now_reg);
        tgt_x = 34'(offset_target_reg);
        dx_x  = $signed({2'b00, dx_reg});
        if (off_x < tgt_x)
        begin
            off_sum = off_x + dx_x;
        end
        else if (off_x >= tgt_x + dx_x)
        begin
            off_sum = off_x - dx_x;
        end
        else
        begin
            off_sum = off_x;
        end
        if (off_sum > 34'sd2147483647)
        begin
            off_next = 32'sh7FFF_FFFF;
        end
        else if (off_sum < -34'sd2147483648)
        begin
            off_next = 32'sh8000_0000;
        end
        else
        begin
            off_next = off_sum[31:0];
        end
    end

    // ROM index of the stored phase: floor(phase * depth / 2^32).
    logic [IPROD_W-1:0] idx_prod;
    assign idx_prod = IPROD_W'(phase_acc_reg) * IPROD_W'(SINE_DEPTH);

    // Target amplitude product.
    logic signed [18:0] amp_s;
    logic signed [34:0] amp_prod;
    assign amp_s    = $signed({1'b0, amplitude_reg});
    assign amp_prod = amp_s * rom_data;

    // Step decision against the Q21.16 target.
    logic signed [36:0]          tgt;
    logic signed [20:0]          tgt_floor;
    logic                        frac_nz;
    logic signed [CMP_W-1:0]     pos_c;
    logic signed [CMP_W-1:0]     ceil_c;
    logic signed [CMP_W-1:0]     fl1_c;
    logic                        step_now;
    logic                        dir_now;
    logic signed [POS_WIDTH-1:0] pos_next;

    assign tgt       = 37'(tprod_reg) + 37'(offset_now_reg);
    assign tgt_floor = tgt[36:16];
    assign frac_nz   = |tgt[15:0];
    assign pos_c     = CMP_W'(position_count_reg);
    assign ceil_c    = CMP_W'(tgt_floor) + CMP_W'($signed({1'b0, frac_nz}));
    assign fl1_c     = CMP_W'(tgt_floor) + CMP_W'(2'sd1);

    always_comb
    begin
        step_now = 1'b0;
        dir_now  = 1'b0;
        pos_next = position_count_reg;
        if (!released)
        begin
            if (pos_c < ceil_c)
            begin
                if (position_count_reg != POS_MAX)
                begin
                    step_now = 1'b1;
                    dir_now  = 1'b1;
                    pos_next = position_count_reg + POS_WIDTH'(1);
                end
            end
            else if (pos_c > fl1_c)
            begin
                if (position_count_reg != POS_MIN)
                begin
                    step_now = 1'b1;
                    pos_next = position_count_reg - POS_WIDTH'(1);
                end
            end
        end
    end

    // DAC error: position in Q16.16 minus the offset, clamped so the product
    // stays bounded without changing the saturated code.
    logic signed [PX_W-1:0] pos_x;
    logic signed [PX_W-1:0] pos_cl;
    logic signed [57:0]     err;
    logic                   err_neg;
    logic [56:0]            err_mag;

    assign pos_x  = PX_W'(position_count_reg);
    assign pos_cl = (pos_x > DAC_LIM_HI) ? DAC_LIM_HI :
                    ((pos_x < DAC_LIM_LO) ? DAC_LIM_LO : pos_x);
    assign err     = $signed({pos_cl[41:0], 16'h0000}) - 58'(offset_now_reg);
    assign err_neg = err[57];
    assign err_mag = err_neg ? 57'(-err) : 57'(err);

    // DAC code from the two partial products of |err| * gain / 2^32.
    logic [49:0]      mint;
    logic [50:0]      mint_up;
    logic             rem_nz;
    logic [8:0]       code_sum;
    logic [DAC_W-1:0] code_now;

    assign mint     = 50'(hi_reg) + 50'(lo_reg[55:32]);
    assign rem_nz   = |lo_reg[31:0];
    assign mint_up  = 51'(mint) + 51'(rem_nz);
    assign code_sum = 9'(mint[7:0]) + 9'd128;

    always_comb
    begin
        if (!upd_reg)
        begin
            code_now = '0;
        end
        else if (!neg_reg)
        begin
            if (mint >= 50'd256 || code_sum > 9'd255)
            begin
                code_now = 8'd255;
            end
            else
            begin
                code_now = code_sum[7:0];
            end
        end
        else
        begin
            // Rounding toward minus infinity for a negative error.
            if (mint_up >= 51'd128)
            begin
                code_now = 8'd0;
            end
            else
            begin
                code_now = 8'd128 - mint_up[7:0];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Configuration and persistent state.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg       <= MODE_RELEASED;
            phase_rate_reg     <= 32'd4295;
            amplitude_reg      <= 18'd102;
            offset_target_reg  <= '0;
            offset_slew_reg    <= 16'd334;
            dac_gain_reg       <= 24'd81593;
            dac_period_reg     <= 16'd500;
            phase_acc_reg      <= '0;
            phase_idx_reg      <= '0;
            position_count_reg <= '0;
            offset_now_reg     <= '0;
            dac_timer_reg      <= '0;
            pulse_done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RUN_MODE:
                    begin
                        run_mode_reg   <= run_mode_t'(cfg_data[1:0]);
                        pulse_done_reg <= 1'b0;
                    end
                    CFG_PHASE_RATE:  phase_rate_reg    <= cfg_data;
                    CFG_AMPLITUDE:   amplitude_reg     <= cfg_data[17:0];
                    CFG_OFFSET_TGT:  offset_target_reg <= $signed(cfg_data);
                    CFG_OFFSET_SLEW: offset_slew_reg   <= cfg_data[15:0];
                    CFG_DAC_GAIN:    dac_gain_reg      <= cfg_data[23:0];
                    CFG_DAC_PERIOD:  dac_period_reg    <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_CALC)
            begin
                dac_timer_reg <= upd_now ? 17'd0 : timer_sat;
            end

            if (state_reg == ST_PHASE)
            begin
                offset_now_reg <= off_next;
                if (go_reg)
                begin
                    phase_acc_reg <= phase_sum[31:0];
                end
                if (run_mode_reg == MODE_PULSE && !pulse_done_reg && phase_wrap)
                begin
                    pulse_done_reg <= 1'b1;
                end
            end

            if (state_reg == ST_INDEX)
            begin
                phase_idx_reg <= idx_prod[32 +: IDX_W];
            end

            if (state_reg == ST_STEP)
            begin
                position_count_reg <= pos_next;
            end
        end
    end

    // Per-tick working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            el_reg <= tick.elapsed_us;
        end
        if (state_reg == ST_CALC)
        begin
            dx_reg      <= 32'(offset_slew_reg) * 32'(el_reg);
            adv_reg     <= 48'(phase_rate_reg) * 48'(el_reg);
            go_reg      <= go_now;
            upd_reg     <= upd_now;
            disable_reg <= released;
        end
        if (state_reg == ST_TARGET)
        begin
            tprod_reg <= {amp_prod, 1'b0};
        end
        if (state_reg == ST_STEP)
        begin
            step_reg <= step_now;
            dir_reg  <= dir_now;
        end
        if (state_reg == ST_DAC_ERR)
        begin
            neg_reg <= err_neg;
            mag_reg <= err_mag;
        end
        if (state_reg == ST_DAC_MUL)
        begin
            hi_reg <= 49'(mag_reg[56:32]) * 49'(dac_gain_reg);
            lo_reg <= 56'(mag_reg[31:0]) * 56'(dac_gain_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Output register: decouples the result side from the sequencer.
    // ---------------------------------------------------------------------
    logic signed [PE_W-1:0] pos_ext;
    assign pos_ext = PE_W'(position_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_disable_reg  <= disable_reg;
            out_pulse_reg    <= step_reg;
            out_dir_reg      <= dir_reg;
            out_position_reg <= pos_ext[POSOUT_W-1:0];
            out_update_reg   <= upd_reg;
            out_code_reg     <= code_now;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.drive_disable  = out_disable_reg;
    assign result.step_pulse     = out_pulse_reg;
    assign result.step_direction = out_dir_reg;
    assign result.step_position  = out_position_reg;
    assign result.dac_update     = out_update_reg;
    assign result.dac_value      = out_code_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `SSPD_ASSERT_SAME(a_released_is_quiet,
        result.valid && result.drive_disable,
        !result.step_pulse && !result.dac_update,
        "released driver reported a step or a DAC refresh")
    `SSPD_ASSERT_SAME(a_code_only_on_update,
        result.valid && !result.dac_update,
        result.dac_value == '0,
        "DAC code is nonzero without a refresh")
    `SSPD_ASSERT_NEXT(a_accept_starts_sequence,
        tick.valid && tick.ready,
        state_reg == ST_CALC,
        "accepted tick did not start the sequencer")
    `SSPD_ASSERT_NEXT(a_position_moves_once,
        state_reg != ST_STEP,
        $stable(position_count_reg),
        "position counter changed outside the step cycle")

endmodule

[rtl/sspd_sine_rom.sv]
// Sine lookup ROM with a registered read port, one full period of signed Q1.15.
// Depends on sspd_pkg for the series evaluator that builds the contents.
module sspd_sine_rom #(
    parameter int SINE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic [$clog2(SINE_DEPTH)-1:0] addr,
    output logic signed [15:0]            data
);
    import sspd_pkg::*;

    logic signed [15:0] sine_rom [SINE_DEPTH];
    logic signed [15:0] data_reg;

    // Each entry folds its index into the first quadrant and takes the sign
    // from the half period it falls in.
    for (genvar k = 0; k < SINE_DEPTH; k++)
    begin : g_entry
        localparam longint unsigned NUM   = 64'(k) * 64'd4;
        localparam longint unsigned QUAD  = NUM / SINE_DEPTH;
        localparam longint unsigned REM   = NUM % SINE_DEPTH;
        localparam longint unsigned ANG   = (QUAD % 2 == 1) ? (SINE_DEPTH - REM) : REM;
        localparam longint unsigned THETA = ANG * HALF_PI_Q30 / SINE_DEPTH;
        localparam logic [14:0]     MAG   = sine_mag(THETA);
        localparam logic signed [15:0] POS_VAL = $signed({1'b0, MAG});

        assign sine_rom[k] = (QUAD >= 2) ? -POS_VAL : POS_VAL;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= sine_rom[addr];
    end

    assign data = data_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for sine_stepper_position_driver_core: tick transactions in,
// one result transaction out per tick, each checked against a predictor or a typed value.
// Depends on sspd_pkg, the sspd_tick_if / sspd_result_if interfaces and the core RTL.
module tb_top;
    import sspd_pkg::*;

    // Fixed-point constants of the drive, kept local to the predictor.
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint          FULL_TURN        = 64'sd4294967296;
    localparam int              NEAR_ZERO_LEVEL  = 327;
    localparam int              TIMER_CEILING    = 131071;
    localparam longint          POS_TOP          = 64'sd2147483647;
    localparam longint          POS_BOTTOM       = -64'sd2147483648;
    localparam longint          DAC_CLAMP        = 64'sd1 <<< 40;

    // Stopping points for the stimulus and the watchdog.
    localparam int RANDOM_TICKS = 410;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        drive_disable;
        logic        step_pulse;
        logic        step_direction;
        logic [31:0] step_position;
        logic        dac_update;
        logic [7:0]  dac_value;
    } drive_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_TICK_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        cfg_index_t    reg_index;
        logic [31:0]   value;
        logic [15:0]   elapsed;
        drive_result_t want;
    } stim_row_t;

    // A released driver that has never moved: disabled, no step, no refresh.
    localparam drive_result_t AT_REST_RELEASED = '{1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 8'd0};
    localparam drive_result_t UNCHECKED        = '0;

    // The directed part. Writes are only issued once every earlier tick has
    // produced its result. The first ticks run out of reset in released mode,
    // where the outcome is obvious and typed in; two large ticks bring the refresh
    // timer just below its ceiling. The rest walks every mode, zero amplitude
    // and gain, both offset extremes with the fastest slew (so the sync code
    // pins at both ends), the longest refresh period, a stalled phase, and the
    // single pulse mode being completed and then rearmed by a mode write.
    localparam int N_DIRECTED = 38;
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_TICK_TYPED, CFG_RUN_MODE,    32'd0,          16'd0,     AT_REST_RELEASED},
        '{ROW_TICK_TYPED, CFG_RUN_MODE,    32'd0,          16'd65535, AT_REST_RELEASED},
        '{ROW_TICK_TYPED, CFG_RUN_MODE,    32'd0,          16'd65535, AT_REST_RELEASED},
        '{ROW_WRITE,      CFG_RUN_MODE,    32'(MODE_SINE), 16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd1,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd300,   UNCHECKED},
        '{ROW_WRITE,      CFG_AMPLITUDE,   32'd0,          16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_DAC_GAIN,    32'd0,          16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd600,   UNCHECKED},
        '{ROW_WRITE,      CFG_AMPLITUDE,   32'd262143,     16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_DAC_GAIN,    32'h00FF_FFFF,  16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_DAC_PERIOD,  32'd0,          16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_OFFSET_TGT,  32'h7FFF_FFFF,  16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_OFFSET_SLEW, 32'h0000_FFFF,  16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd65535, UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd1,     UNCHECKED},
        '{ROW_WRITE,      CFG_OFFSET_TGT,  32'h8000_0000,  16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd65535, UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd65535, UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd7,     UNCHECKED},
        '{ROW_WRITE,      CFG_DAC_PERIOD,  32'h0000_FFFF,  16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_OFFSET_SLEW, 32'd0,          16'd0,     UNCHECKED},
        '{ROW_WRITE,      CFG_PHASE_RATE,  32'd0,          16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd500,   UNCHECKED},
        '{ROW_WRITE,      CFG_RUN_MODE,    32'(MODE_BRAKE), 16'd0,    UNCHECKED},
        '{ROW_WRITE,      CFG_PHASE_RATE,  32'h0010_0000,  16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd3,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd40,    UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd40,    UNCHECKED},
        '{ROW_WRITE,      CFG_RUN_MODE,    32'(MODE_PULSE), 16'd0,    UNCHECKED},
        '{ROW_WRITE,      CFG_PHASE_RATE,  32'hFFFF_FFFF,  16'd0,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd1,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd1,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd2,     UNCHECKED},
        '{ROW_WRITE,      CFG_RUN_MODE,    32'(MODE_PULSE), 16'd0,    UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd1,     UNCHECKED},
        '{ROW_TICK,       CFG_RUN_MODE,    32'd0,          16'd12,    UNCHECKED}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sspd_tick_if   tick_ch ();
    sspd_result_if result_ch ();

    sine_stepper_position_driver_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    // Register copies held by the predictor.
    run_mode_t set_mode;
    longint    set_rate;
    longint    set_amplitude;
    longint    set_center_goal;
    longint    set_center_slew;
    longint    set_dac_gain;
    longint    set_refresh_us;

    // Drive state held by the predictor.
    longint model_phase;
    longint model_position;
    longint model_center;
    int     model_since_refresh;
    bit     model_pulse_spent;
    int     sine_q15 [1024];

    // Expected results, oldest first, one per accepted tick transaction.
    drive_result_t outputs_due [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int random_ticks   = 0;

    // While set, neither side inserts gaps, so some phases run back to back.
    bit calm = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a run that hangs on a lost handshake ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One sine table entry in Q1.15: the angle of the folded first-quadrant
    // index in Q30 radians, then a seven-term Taylor series in integers.
    function automatic int sine_q15_entry(input int k);
        longint unsigned quarter;
        longint unsigned rest;
        longint unsigned u;
        longint unsigned theta;
        longint unsigned theta_sq;
        longint unsigned term;
        longint          sum;
        longint          mag;
        quarter  = (4 * k) / 1024;
        rest     = (4 * k) % 1024;
        u        = quarter[0] ? 1024 - rest : rest;
        theta    = u * QUARTER_TURN_Q30 / 1024;
        theta_sq = (theta * theta) >> 30;
        term     = theta;
        sum      = longint'(theta);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * theta_sq) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 16384) / 32768;
        if (mag > 32767)
            mag = 32767;
        return (quarter >= 2) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int sine_at_phase(input longint phase);
        return sine_q15[10'(phase >> 22)];
    endfunction

    // Sync DAC code: 128 plus the position error scaled by the gain, taken as
    // a 64x24 product split in two halves and saturated to 0..255. Negative
    // errors round away from zero before they are subtracted from mid-scale.
    function automatic logic [7:0] sync_dac_code(input longint pos, input longint center,
                                                 input longint gain);
        longint          err;
        longint unsigned mag;
        longint unsigned low_prod;
        longint unsigned whole;
        bit              negative;
        if (pos > DAC_CLAMP)
            pos = DAC_CLAMP;
        if (pos < -DAC_CLAMP)
            pos = -DAC_CLAMP;
        err      = pos * 65536 - center;
        negative = err < 0;
        mag      = negative ? -err : err;
        low_prod = (mag & 64'h0000_0000_FFFF_FFFF) * gain;
        whole    = (mag >> 32) * gain + (low_prod >> 32);
        if (!negative)
            return (whole >= 128) ? 8'd255 : 8'(128 + whole);
        if (low_prod[31:0] != 0)
            whole++;
        return (whole >= 128) ? 8'd0 : 8'(128 - whole);
    endfunction

    function automatic void reset_drive_model();
        set_mode            = MODE_RELEASED;
        set_rate            = 4295;
        set_amplitude       = 102;
        set_center_goal     = 0;
        set_center_slew     = 334;
        set_dac_gain        = 81593;
        set_refresh_us      = 500;
        model_phase         = 0;
        model_position      = 0;
        model_center        = 0;
        model_since_refresh = 0;
        model_pulse_spent   = 1'b0;
        for (int k = 0; k < 1024; k++)
            sine_q15[k] = sine_q15_entry(k);
    endfunction

    // Advances the drive by one tick and returns the result it must produce.
    function automatic drive_result_t next_drive_outputs(input logic [15:0] elapsed);
        drive_result_t r;
        longint        slew_step;
        longint        advance;
        longint        target;
        longint        ceil_pos;
        longint        floor_pos;
        int            s;
        bit            moves;
        r = '0;

        // The center slews toward its goal in every mode, then saturates.
        slew_step = set_center_slew * longint'(elapsed);
        if (model_center < set_center_goal)
            model_center = model_center + slew_step;
        else if (model_center >= set_center_goal + slew_step)
            model_center = model_center - slew_step;
        if (model_center > POS_TOP)
            model_center = POS_TOP;
        if (model_center < POS_BOTTOM)
            model_center = POS_BOTTOM;

        model_since_refresh = model_since_refresh + int'(elapsed);
        if (model_since_refresh > TIMER_CEILING)
            model_since_refresh = TIMER_CEILING;

        if (set_mode == MODE_RELEASED)
        begin
            r.drive_disable = 1'b1;
        end
        else
        begin
            // Whether the phase moves is decided on the sine of the old phase.
            advance = set_rate * longint'(elapsed);
            s       = sine_at_phase(model_phase);
            if (set_mode == MODE_SINE)
            begin
                moves = 1'b1;
            end
            else if (set_mode == MODE_PULSE && !model_pulse_spent)
            begin
                moves = 1'b1;
                if (model_phase + advance >= FULL_TURN)
                    model_pulse_spent = 1'b1;
            end
            else
            begin
                moves = (s > NEAR_ZERO_LEVEL) || (s < -NEAR_ZERO_LEVEL);
            end
            if (moves)
                model_phase = (model_phase + advance) % FULL_TURN;

            // Target in Q16.16 from the new phase; one step at most, with a
            // dead band of one microstep above the floor of the target.
            s         = sine_at_phase(model_phase);
            target    = 2 * set_amplitude * longint'(s) + model_center;
            floor_pos = target >>> 16;
            ceil_pos  = floor_pos;
            if (target[15:0] != 16'd0)
                ceil_pos++;
            if (model_position < ceil_pos)
            begin
                if (model_position < POS_TOP)
                begin
                    model_position++;
                    r.step_pulse     = 1'b1;
                    r.step_direction = 1'b1;
                end
            end
            else if (model_position > floor_pos + 1)
            begin
                if (model_position > POS_BOTTOM)
                begin
                    model_position--;
                    r.step_pulse = 1'b1;
                end
            end

            if (model_since_refresh > set_refresh_us)
            begin
                r.dac_update        = 1'b1;
                r.dac_value         = sync_dac_code(model_position, model_center, set_dac_gain);
                model_since_refresh = 0;
            end
        end
        r.step_position = model_position[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] random_elapsed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 16'($urandom_range(0, 100));
        if (roll < 85)
            return 16'($urandom_range(0, 2000));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
    endtask

    // A register write drives the enable high and waits for the clock, then drives
    // it low and waits again, so the enable never gets two updates in one time step.
    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_RUN_MODE:
            begin
                set_mode          = run_mode_t'(value[1:0]);
                model_pulse_spent = 1'b0;
            end
            CFG_PHASE_RATE:  set_rate        = longint'(value);
            CFG_AMPLITUDE:   set_amplitude   = longint'(value[17:0]);
            CFG_OFFSET_TGT:  set_center_goal = longint'($signed(value));
            CFG_OFFSET_SLEW: set_center_slew = longint'(value[15:0]);
            CFG_DAC_GAIN:    set_dac_gain    = longint'(value[23:0]);
            CFG_DAC_PERIOD:  set_refresh_us  = longint'(value[15:0]);
            default: ;
        endcase
    endtask

    // Offers one tick transaction after an optional gap and records what it
    // must produce. Valid stays high after acceptance, so back-to-back ticks
    // only change the payload.
    task automatic send_tick(input logic [15:0] elapsed, input bit typed,
                             input drive_result_t typed_want);
        int            gap;
        drive_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.elapsed_us <= elapsed;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = next_drive_outputs(elapsed);
        if (typed)
            outputs_due.push_back(typed_want);
        else
            outputs_due.push_back(predicted);
    endtask

    // Every tick yields a result, so the block is idle once none is pending.
    task automatic wait_until_idle();
        if (tick_ch.valid)
            tick_ch.valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge clk);
    endtask

    // A new setting for a random phase: most registers take values that keep
    // the motor tracking and the sync output moving, with the extremes mixed in.
    task automatic randomize_config();
        int roll;
        if ($urandom_range(0, 3) != 0)
        begin
            roll = $urandom_range(0, 19);
            if (roll < 7)
                cfg_write(CFG_RUN_MODE, 32'(MODE_SINE));
            else if (roll < 12)
                cfg_write(CFG_RUN_MODE, 32'(MODE_BRAKE));
            else if (roll < 17)
                cfg_write(CFG_RUN_MODE, 32'(MODE_PULSE));
            else
                cfg_write(CFG_RUN_MODE, 32'(MODE_RELEASED));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                cfg_write(CFG_PHASE_RATE, 32'd0);
            else if (roll < 20)
                cfg_write(CFG_PHASE_RATE, 32'hFFFF_FFFF);
            else if (roll < 40)
                cfg_write(CFG_PHASE_RATE, $urandom);
            else
                cfg_write(CFG_PHASE_RATE, $urandom_range(1000, 4000000));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                cfg_write(CFG_AMPLITUDE, 32'd0);
            else if (roll < 10)
                cfg_write(CFG_AMPLITUDE, 32'd262143);
            else if (roll < 30)
                cfg_write(CFG_AMPLITUDE, $urandom_range(0, 262143));
            else
                cfg_write(CFG_AMPLITUDE, $urandom_range(1, 300));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                cfg_write(CFG_OFFSET_TGT, 32'h7FFF_FFFF);
            else if (roll < 10)
                cfg_write(CFG_OFFSET_TGT, 32'h8000_0000);
            else if (roll < 25)
                cfg_write(CFG_OFFSET_TGT, $urandom);
            else
                cfg_write(CFG_OFFSET_TGT,
                          32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                cfg_write(CFG_OFFSET_SLEW, 32'd0);
            else if (roll < 15)
                cfg_write(CFG_OFFSET_SLEW, 32'd65535);
            else if (roll < 60)
                cfg_write(CFG_OFFSET_SLEW, $urandom_range(1, 2000));
            else
                cfg_write(CFG_OFFSET_SLEW, $urandom_range(0, 65535));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                cfg_write(CFG_DAC_GAIN, 32'd0);
            else if (roll < 10)
                cfg_write(CFG_DAC_GAIN, 32'h00FF_FFFF);
            else if (roll < 40)
                cfg_write(CFG_DAC_GAIN, $urandom_range(0, 32'h00FF_FFFF));
            else
                cfg_write(CFG_DAC_GAIN, $urandom_range(1000, 200000));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                cfg_write(CFG_DAC_PERIOD, 32'd0);
            else if (roll < 15)
                cfg_write(CFG_DAC_PERIOD, 32'd65535);
            else if (roll < 80)
                cfg_write(CFG_DAC_PERIOD, $urandom_range(0, 300));
            else
                cfg_write(CFG_DAC_PERIOD, $urandom_range(0, 65535));
        end
    endtask

    // Compares one accepted result with the oldest pending expectation.
    task automatic check_result();
        drive_result_t want;
        if (outputs_due.size() == 0)
        begin
            report_mismatch("result with no tick pending, step_position",
                            longint'(result_ch.step_position), 0);
            return;
        end
        want = outputs_due.pop_front();
        if (result_ch.drive_disable !== want.drive_disable)
            report_mismatch("drive_disable", result_ch.drive_disable, want.drive_disable);
        if (result_ch.step_pulse !== want.step_pulse)
            report_mismatch("step_pulse", result_ch.step_pulse, want.step_pulse);
        if (result_ch.step_direction !== want.step_direction)
            report_mismatch("step_direction", result_ch.step_direction, want.step_direction);
        if (result_ch.step_position !== want.step_position)
            report_mismatch("step_position", longint'(result_ch.step_position),
                            longint'($signed(want.step_position)));
        if (result_ch.dac_update !== want.dac_update)
            report_mismatch("dac_update", result_ch.dac_update, want.dac_update);
        if (result_ch.dac_value !== want.dac_value)
            report_mismatch("dac_value", result_ch.dac_value, want.dac_value);
    endtask

    // Result side: checks every accepted result transaction and stalls ready
    // at random, mostly briefly and now and then for much longer.
    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Tick side and configuration: reset, the directed table, then random
    // phases, each a fresh setting followed by a burst of ticks.
    initial
    begin
        int burst;
        cfg_we             = 1'b0;
        cfg_index          = CFG_RUN_MODE;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.elapsed_us = '0;
        reset_drive_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_WRITE:
                begin
                    wait_until_idle();
                    cfg_write(directed_rows[i].reg_index, directed_rows[i].value);
                end
                ROW_TICK:
                    send_tick(directed_rows[i].elapsed, 1'b0, UNCHECKED);
                default:
                    send_tick(directed_rows[i].elapsed, 1'b1, directed_rows[i].want);
            endcase
        end

        while (random_ticks < RANDOM_TICKS)
        begin
            wait_until_idle();
            calm = ($urandom_range(0, 3) == 0);
            randomize_config();
            burst = $urandom_range(15, 50);
            repeat (burst)
            begin
                send_tick(random_elapsed(), 1'b0, UNCHECKED);
                random_ticks++;
            end
        end

        // Let the last results arrive, then watch a while for strays.
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
